// ----- src/bpi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpi_pkg;

  localparam int ElevW    = 24;
  localparam int SlopeW   = 48;
  localparam int CtrlW    = 27;
  localparam int OutW     = 26;
  localparam int NumPts   = 16;
  localparam int NumCorners = 4;

  localparam int ApbDataW = 64;
  localparam int ApbAddrW = 6;

  // floor(n / 3) = (n * Recip3) >> Recip3Shift, exact for any 32-bit n
  localparam int              Recip3W     = 32;
  localparam logic [31:0]     Recip3      = 32'hAAAA_AAAB;
  localparam int              Recip3Shift = 33;
  localparam int              DivW        = 29;

  localparam int CornerSw = 0;
  localparam int CornerSe = 1;
  localparam int CornerNw = 2;
  localparam int CornerNe = 3;

  typedef enum logic [2:0] {
    REG_ELEV_SW  = 3'd0,
    REG_ELEV_SE  = 3'd1,
    REG_ELEV_NW  = 3'd2,
    REG_ELEV_NE  = 3'd3,
    REG_SLOPE_SW = 3'd4,
    REG_SLOPE_SE = 3'd5,
    REG_SLOPE_NW = 3'd6,
    REG_SLOPE_NE = 3'd7
  } reg_idx_e;

  typedef logic signed [CtrlW-1:0] ctrl_pt_t;
  typedef ctrl_pt_t ctrl_grid_t [NumPts];

endpackage

`default_nettype wire

// ----- src/bpi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bpi_in_if #(
  parameter int FracBits = 16
);
  logic                valid;
  logic                ready;
  logic [FracBits:0]   pos_x;
  logic [FracBits:0]   pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface bpi_out_if;
  import bpi_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

`default_nettype wire

// ----- src/bpi_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpi_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpi_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bpi_pkg::ApbDataW-1:0]  pwdata,
  output logic [bpi_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output bpi_pkg::ctrl_grid_t           grid_o
);
  import bpi_pkg::*;

  logic [ElevW-1:0]  elev_q  [NumCorners];
  logic [SlopeW-1:0] slope_q [NumCorners];
  reg_idx_e          idx;
  logic              wr_en;
  ctrl_grid_t        grid_d;
  ctrl_grid_t        grid_q;

  function automatic ctrl_pt_t sx(input logic [ElevW-1:0] v);
    return ctrl_pt_t'($signed(v));
  endfunction

  function automatic ctrl_pt_t times3(input ctrl_pt_t v);
    return (v <<< 1) + v;
  endfunction

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCorners; k++) begin
        elev_q[k]  <= '0;
        slope_q[k] <= '0;
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_ELEV_SW:  elev_q[CornerSw]  <= pwdata[ElevW-1:0];
        REG_ELEV_SE:  elev_q[CornerSe]  <= pwdata[ElevW-1:0];
        REG_ELEV_NW:  elev_q[CornerNw]  <= pwdata[ElevW-1:0];
        REG_ELEV_NE:  elev_q[CornerNe]  <= pwdata[ElevW-1:0];
        REG_SLOPE_SW: slope_q[CornerSw] <= pwdata[SlopeW-1:0];
        REG_SLOPE_SE: slope_q[CornerSe] <= pwdata[SlopeW-1:0];
        REG_SLOPE_NW: slope_q[CornerNw] <= pwdata[SlopeW-1:0];
        REG_SLOPE_NE: slope_q[CornerNe] <= pwdata[SlopeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ELEV_SW:  prdata = ApbDataW'(elev_q[CornerSw]);
      REG_ELEV_SE:  prdata = ApbDataW'(elev_q[CornerSe]);
      REG_ELEV_NW:  prdata = ApbDataW'(elev_q[CornerNw]);
      REG_ELEV_NE:  prdata = ApbDataW'(elev_q[CornerNe]);
      REG_SLOPE_SW: prdata = ApbDataW'(slope_q[CornerSw]);
      REG_SLOPE_SE: prdata = ApbDataW'(slope_q[CornerSe]);
      REG_SLOPE_NW: prdata = ApbDataW'(slope_q[CornerNw]);
      REG_SLOPE_NE: prdata = ApbDataW'(slope_q[CornerNe]);
      default: ;
    endcase
  end

  // control points scaled by 3; row index runs north, column east
  always_comb begin
    grid_d[0]  = times3(sx(elev_q[CornerSw]));
    grid_d[3]  = times3(sx(elev_q[CornerSe]));
    grid_d[12] = times3(sx(elev_q[CornerNw]));
    grid_d[15] = times3(sx(elev_q[CornerNe]));
    grid_d[1]  = grid_d[0]  + sx(slope_q[CornerSw][ElevW-1:0]);
    grid_d[4]  = grid_d[0]  + sx(slope_q[CornerSw][SlopeW-1:ElevW]);
    grid_d[2]  = grid_d[3]  - sx(slope_q[CornerSe][ElevW-1:0]);
    grid_d[7]  = grid_d[3]  + sx(slope_q[CornerSe][SlopeW-1:ElevW]);
    grid_d[13] = grid_d[12] + sx(slope_q[CornerNw][ElevW-1:0]);
    grid_d[8]  = grid_d[12] - sx(slope_q[CornerNw][SlopeW-1:ElevW]);
    grid_d[14] = grid_d[15] - sx(slope_q[CornerNe][ElevW-1:0]);
    grid_d[11] = grid_d[15] - sx(slope_q[CornerNe][SlopeW-1:ElevW]);
    grid_d[5]  = grid_d[1]  + grid_d[4]  - grid_d[0];
    grid_d[6]  = grid_d[2]  + grid_d[7]  - grid_d[3];
    grid_d[9]  = grid_d[13] + grid_d[8]  - grid_d[12];
    grid_d[10] = grid_d[14] + grid_d[11] - grid_d[15];
  end

  always_ff @(posedge clk_i) begin
    grid_q <= grid_d;
  end

  assign grid_o = grid_q;

endmodule

`default_nettype wire

// ----- src/bpi_weight_gen.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpi_weight_gen #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic [FRAC_BITS:0]   pos_i,
  output logic [FRAC_BITS:0]   w_o [4]
);

  localparam int PosW = FRAC_BITS + 1;
  localparam int MulW = 2 * PosW;
  localparam logic [PosW-1:0] PosOne    = PosW'(1) << FRAC_BITS;
  localparam logic [MulW-1:0] RoundHalf = MulW'(1) << (FRAC_BITS - 1);

  function automatic logic [PosW-1:0] wmul(input logic [PosW-1:0] a,
                                           input logic [PosW-1:0] b);
    logic [MulW-1:0] p;
    p = MulW'(a) * MulW'(b) + RoundHalf;
    return PosW'(p >> FRAC_BITS);
  endfunction

  function automatic logic [PosW-1:0] times3(input logic [PosW-1:0] v);
    return PosW'({v, 1'b0} + (PosW + 1)'(v));
  endfunction

  logic [PosW-1:0] t1_q, u1_q;
  logic [PosW-1:0] t2_q, u2_q, tt_q, uu_q;
  logic [PosW-1:0] w_q [4];
  logic [PosW-1:0] t_clamp;

  assign t_clamp = (pos_i > PosOne) ? PosOne : pos_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q <= t_clamp;
      u1_q <= PosOne - t_clamp;
    end
    if (en_i[1]) begin
      t2_q <= t1_q;
      u2_q <= u1_q;
      tt_q <= wmul(t1_q, t1_q);
      uu_q <= wmul(u1_q, u1_q);
    end
    if (en_i[2]) begin
      w_q[0] <= wmul(uu_q, u2_q);
      w_q[1] <= times3(wmul(uu_q, t2_q));
      w_q[2] <= times3(wmul(u2_q, tt_q));
      w_q[3] <= wmul(tt_q, t2_q);
    end
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

// ----- src/bpi_patch_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpi_patch_sum #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic [5:0]                     en_i,
  input  bpi_pkg::ctrl_grid_t            grid_i,
  input  logic [FRAC_BITS:0]             bx_i [4],
  input  logic [FRAC_BITS:0]             by_i [4],
  output logic signed [bpi_pkg::OutW-1:0] elevation_o
);
  import bpi_pkg::*;

  localparam int WtW      = FRAC_BITS + 1;
  localparam int RowShift = (2 * FRAC_BITS > 36) ? 2 * FRAC_BITS - 36 : 0;
  localparam int ProdW    = CtrlW + WtW + 1;
  localparam int SumW     = ProdW + 2;
  localparam int RowW     = FRAC_BITS + 28 - RowShift;
  localparam int LoW      = 24;
  localparam int HiW      = RowW - LoW;
  localparam int PpLoW    = LoW + WtW;
  localparam int PpHiW    = HiW + WtW + 1;
  localparam int AccW     = RowW + WtW + 3;
  localparam int FinShift = 2 * FRAC_BITS - RowShift;
  localparam int NumW     = DivW + 1;
  localparam int RecProdW = NumW + Recip3W;

  localparam logic signed [SumW-1:0] RowHalf  = SumW'((64'd1 << RowShift) >> 1);
  localparam logic signed [AccW-1:0] FinHalf  = AccW'(3) <<< (FinShift - 1);
  localparam logic [NumW-1:0]        NumOff   = NumW'(3) << (DivW - 1);
  localparam logic signed [NumW-1:0] QuoOff   = NumW'(1) <<< (DivW - 1);
  localparam logic signed [NumW-1:0] SatHi    = NumW'((1 << (OutW - 1)) - 1);
  localparam logic signed [NumW-1:0] SatLo    = -(NumW'(1) <<< (OutW - 1));

  logic signed [ProdW-1:0] prod_q [NumPts];
  logic [WtW-1:0]          by3_q [4];
  logic [WtW-1:0]          by4_q [4];
  logic signed [SumW-1:0]  row_sum [4];
  logic signed [RowW-1:0]  row_q [4];
  logic [PpLoW-1:0]        pp_lo_q [4];
  logic signed [PpHiW-1:0] pp_hi_q [4];
  logic signed [AccW-1:0]  acc;
  logic signed [DivW-1:0]  div_in_q;
  logic [NumW-1:0]         num;
  logic [RecProdW-1:0]     rec_prod;
  logic [DivW-1:0]         quo_q;
  logic signed [NumW-1:0]  quo;
  logic signed [OutW-1:0]  elev_d;
  logic signed [OutW-1:0]  elev_q;

  // products of control points and east weights
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NumPts; k++) begin
        prod_q[k] <= ProdW'(grid_i[k]) * ProdW'($signed({1'b0, bx_i[k & 3]}));
      end
      by3_q <= by_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_sum[i] = SumW'(prod_q[4*i]) + SumW'(prod_q[4*i+1])
                 + SumW'(prod_q[4*i+2]) + SumW'(prod_q[4*i+3]) + RowHalf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 4; i++) begin
        row_q[i] <= RowW'(row_sum[i] >>> RowShift);
      end
      by4_q <= by3_q;
    end
  end

  // row times north weight, split in two partial products
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 4; i++) begin
        pp_lo_q[i] <= PpLoW'(row_q[i][LoW-1:0]) * PpLoW'(by4_q[i]);
        pp_hi_q[i] <= PpHiW'($signed(row_q[i][RowW-1:LoW]))
                    * PpHiW'($signed({1'b0, by4_q[i]}));
      end
    end
  end

  always_comb begin
    acc = FinHalf;
    for (int i = 0; i < 4; i++) begin
      acc = acc + (AccW'(pp_hi_q[i]) <<< LoW) + $signed(AccW'(pp_lo_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      div_in_q <= DivW'(acc >>> FinShift);
    end
  end

  // floor divide by 3 on an offset that keeps the operand positive
  assign num      = NumW'(div_in_q) + NumOff;
  assign rec_prod = RecProdW'(num) * RecProdW'(Recip3);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      quo_q <= DivW'(rec_prod >> Recip3Shift);
    end
  end

  assign quo = $signed({1'b0, quo_q}) - QuoOff;

  always_comb begin
    priority if (quo > SatHi) begin
      elev_d = OutW'(SatHi);
    end else if (quo < SatLo) begin
      elev_d = OutW'(SatLo);
    end else begin
      elev_d = OutW'(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      elev_q <= elev_d;
    end
  end

  assign elevation_o = elev_q;

endmodule

`default_nettype wire

// ----- src/bicubic_patch_interpolator.sv -----
// Bicubic patch interpolator: elevation at a position inside a unit patch.
// Corner elevations and slopes are written over the APB port (64-bit data,
// register i at byte address 8*i) only while no item is in flight; the block
// does not enforce this, so the user must. Reads return the stored value.
// pready is always high. in_i carries one position (pos_x, pos_y,
// Q1.FRAC_BITS, values above 1.0 clamp to 1.0); out_o carries the saturated
// Q25.0 elevation. Both channels move an item on a clock edge with valid and
// ready high.
// Throughput: one item per clock while out_o.ready stays high; every stage is
// a register with its own valid bit, so bubbles are squeezed out and
// in_i.ready stays high as long as any stage is empty or out_o.ready is high.
// When out_o.ready is low the result holds, the stages behind it fill up,
// and in_i.ready drops only once all nine stages hold items.
// Reset clears all valid bits and the configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module bicubic_patch_interpolator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpi_in_if.sink                        in_i,
  bpi_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpi_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bpi_pkg::ApbDataW-1:0]  pwdata,
  output logic [bpi_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bpi_pkg::*;

  localparam int NumStages = 9;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;
  ctrl_grid_t           grid;
  logic [FRAC_BITS:0]   bx [4];
  logic [FRAC_BITS:0]   by [4];

  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = valid_q[NumStages-1];

  bpi_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grid_o  (grid)
  );

  bpi_weight_gen #(.FRAC_BITS(FRAC_BITS)) u_wx (
    .clk_i (clk_i),
    .en_i  (adv[2:0]),
    .pos_i (in_i.pos_x),
    .w_o   (bx)
  );

  bpi_weight_gen #(.FRAC_BITS(FRAC_BITS)) u_wy (
    .clk_i (clk_i),
    .en_i  (adv[2:0]),
    .pos_i (in_i.pos_y),
    .w_o   (by)
  );

  bpi_patch_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk_i       (clk_i),
    .en_i        (adv[8:3]),
    .grid_i      (grid),
    .bx_i        (bx),
    .by_i        (by),
    .elevation_o (out_o.elevation)
  );

endmodule

`default_nettype wire

// ----- sim/bicubic_patch_interpolator_tb.sv -----
`timescale 1ns / 1ps

module bicubic_patch_interpolator_tb;
  import bpi_pkg::*;

  localparam int FracBits = 16;
  localparam int PosW = FracBits + 1;
  localparam int WtW = FracBits + 4;
  localparam int unsigned PosOne = 1 << FracBits;
  localparam int unsigned PosMax = (1 << PosW) - 1;
  localparam int RowShift = (2 * FracBits > 36) ? 2 * FracBits - 36 : 0;
  localparam longint CtlScale = 3;
  localparam longint ElevHi = 33554431;
  localparam longint ElevLo = -33554432;
  localparam int PipeDepth = 9;
  localparam int HoldCycles = 64;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 165;
  localparam int HoldPhase = 2;
  localparam int PausePhase = 4;
  localparam int NumRows = 40;

  typedef enum logic {ROW_POS, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    reg_idx_e               idx;
    logic [63:0]            data;
    logic [PosW-1:0]        x;
    logic [PosW-1:0]        y;
    logic                   known;
    logic signed [OutW-1:0] want;
  } plan_row_t;

  typedef struct packed {
    logic                   known;
    logic signed [OutW-1:0] want;
  } elev_tag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  bpi_in_if #(.FracBits(FracBits)) in_if ();
  bpi_out_if out_if ();

  bicubic_patch_interpolator #(.FRAC_BITS(FracBits)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // patch registers as the block should hold them
  logic signed [ElevW-1:0] cfg_elev [NumCorners];
  logic [SlopeW-1:0] cfg_slope [NumCorners];

  elev_tag_t tag_q [$];
  logic signed [OutW-1:0] elev_q [$];
  int mismatches = 0;
  bit hold_req = 1'b0;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (FracBits - 1))) >> FracBits;
  endfunction

  function automatic longint div_round(longint v, longint d);
    longint w, q;
    w = v + d / 2;
    q = w / d;
    if (w % d < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [3:0][WtW-1:0] bern_wts(logic [PosW-1:0] pos);
    longint unsigned t, u, t2, u2;
    logic [3:0][WtW-1:0] w;
    t = (pos > PosOne) ? longint'(PosOne) : longint'(pos);
    u = longint'(PosOne) - t;
    u2 = qmul(u, u);
    t2 = qmul(t, t);
    w[0] = WtW'(qmul(u2, u));
    w[1] = WtW'(3 * qmul(u2, t));
    w[2] = WtW'(3 * qmul(u, t2));
    w[3] = WtW'(qmul(t2, t));
    return w;
  endfunction

  function automatic logic signed [OutW-1:0] elev_at(logic [PosW-1:0] px,
                                                     logic [PosW-1:0] py);
    longint ctl [NumPts];
    longint ce [NumCorners];
    longint ee [NumCorners];
    longint en [NumCorners];
    logic [3:0][WtW-1:0] wx, wy;
    longint row, acc, res;
    int c, i, j;
    for (c = 0; c < NumCorners; c++) begin
      ce[c] = CtlScale * longint'(cfg_elev[c]);
      ee[c] = longint'($signed(cfg_slope[c][23:0]));
      en[c] = longint'($signed(cfg_slope[c][47:24]));
    end
    ctl[0] = ce[CornerSw];
    ctl[3] = ce[CornerSe];
    ctl[12] = ce[CornerNw];
    ctl[15] = ce[CornerNe];
    ctl[1] = ctl[0] + ee[CornerSw];
    ctl[4] = ctl[0] + en[CornerSw];
    ctl[2] = ctl[3] - ee[CornerSe];
    ctl[7] = ctl[3] + en[CornerSe];
    ctl[13] = ctl[12] + ee[CornerNw];
    ctl[8] = ctl[12] - en[CornerNw];
    ctl[14] = ctl[15] - ee[CornerNe];
    ctl[11] = ctl[15] - en[CornerNe];
    ctl[5] = ctl[1] + ctl[4] - ctl[0];
    ctl[6] = ctl[2] + ctl[7] - ctl[3];
    ctl[9] = ctl[13] + ctl[8] - ctl[12];
    ctl[10] = ctl[14] + ctl[11] - ctl[15];
    wx = bern_wts(px);
    wy = bern_wts(py);
    acc = 0;
    for (i = 0; i < 4; i++) begin
      row = 0;
      for (j = 0; j < 4; j++) row = row + ctl[4 * i + j] * longint'(wx[j]);
      acc = acc + div_round(row, longint'(1) << RowShift) * longint'(wy[i]);
    end
    res = div_round(acc, CtlScale << (2 * FracBits - RowShift));
    if (res > ElevHi) res = ElevHi;
    if (res < ElevLo) res = ElevLo;
    return res[OutW-1:0];
  endfunction

  always @(posedge clk_i) begin
    elev_tag_t tag;
    logic signed [OutW-1:0] want;
    if (rst_ni && in_if.valid && in_if.ready) begin
      tag = tag_q.pop_front();
      elev_q.push_back(tag.known ? tag.want : elev_at(in_if.pos_x, in_if.pos_y));
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (elev_q.size() == 0) begin
        $error("elevation: no item expected, got %0d", out_if.elevation);
        mismatches++;
      end else begin
        want = elev_q.pop_front();
        if (out_if.elevation !== want) begin
          $error("elevation: expected %0d, got %0d", want, out_if.elevation);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin
    int mode, span, n;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
        for (n = 0; n < span; n++) begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 3) != 0);
            2: out_if.ready <= $urandom_range(0, 1);
            default: out_if.ready <= (n % 3 != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= REG_ELEV_NE) cfg_elev[int'(idx) % NumCorners] = data[ElevW-1:0];
    else cfg_slope[int'(idx) % NumCorners] = data[SlopeW-1:0];
    @(posedge clk_i);
  endtask

  task automatic offer_pos(input logic [PosW-1:0] x, input logic [PosW-1:0] y,
                           input elev_tag_t tag);
    tag_q.push_back(tag);
    in_if.valid <= 1'b1;
    in_if.pos_x <= x;
    in_if.pos_y <= y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tag_q.size() != 0 || elev_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_fix24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PosW'(PosOne);
      2: return PosW'($urandom_range(PosOne + 1, PosMax));
      3: return PosW'($urandom);
      default: return PosW'($urandom_range(0, PosOne));
    endcase
  endfunction

  task automatic load_random_patch();
    logic [63:0] d;
    int k;
    for (k = 0; k < 2 * NumCorners; k++) begin
      d = {$urandom, $urandom};
      d[23:0] = rand_fix24();
      if (k >= NumCorners) d[47:24] = rand_fix24();
      reg_write(reg_idx_e'(k), d);
    end
  endtask

  plan_row_t plan [NumRows] = '{
    // reset state: flat zero patch
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd0, 1'b1, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65536, 17'd65536, 1'b1, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd131071, 17'd131071, 1'b1, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd32768, 17'd32768, 1'b0, 26'sd0},
    // corner extremes, junk in the high bits
    '{ROW_REG, REG_ELEV_SW, 64'h0000_0000_007F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_SE, 64'h0000_0000_0080_0000, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_NW, 64'hDEAD_BEEF_FF12_3456, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_NE, 64'hFFFF_FFFF_FFC0_0001, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd0, 1'b1, 26'sd8388607},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65536, 17'd0, 1'b1, -26'sd8388608},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd65536, 1'b1, 26'sd1193046},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65536, 17'd65536, 1'b1, -26'sd4194303},
    // positions past 1.0 clamp to the far edge
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd131071, 17'd0, 1'b1, -26'sd8388608},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd131071, 1'b1, 26'sd1193046},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65537, 17'd65537, 1'b1, -26'sd4194303},
    // slope extremes
    '{ROW_REG, REG_SLOPE_SW, 64'h0000_7FFF_FF7F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_SE, 64'h0000_8000_0080_0000, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_NW, 64'hA5A5_7FFF_FF80_0000, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_NE, 64'h0000_FFFF_FF00_0001, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd0, 1'b1, 26'sd8388607},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65536, 17'd65536, 1'b1, -26'sd4194303},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd32768, 17'd32768, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd1, 17'd1, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65535, 17'd65535, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd16384, 17'd49152, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd32768, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd65536, 17'd32768, 1'b0, 26'sd0},
    // everything at the top of its range
    '{ROW_REG, REG_ELEV_SW, 64'h0000_0000_007F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_SE, 64'h0000_0000_007F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_NW, 64'h0000_0000_007F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_ELEV_NE, 64'h0000_0000_007F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_SE, 64'h0000_7FFF_FF7F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_NW, 64'h0000_7FFF_FF7F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_NE, 64'h0000_7FFF_FF7F_FFFF, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd32768, 17'd32768, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd21845, 17'd43690, 1'b0, 26'sd0},
    // south-west corner at the bottom, the rest still at the top
    '{ROW_REG, REG_ELEV_SW, 64'h0000_0000_0080_0000, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_REG, REG_SLOPE_SW, 64'h0000_8000_0080_0000, 17'd0, 17'd0, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd43690, 17'd21845, 1'b0, 26'sd0},
    '{ROW_POS, REG_ELEV_SW, 64'd0, 17'd0, 17'd0, 1'b1, -26'sd8388608}
  };

  initial begin
    int r, p, sent, burst, gap, k;
    in_if.valid <= 1'b0;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (k = 0; k < NumCorners; k++) begin
      cfg_elev[k] = '0;
      cfg_slope[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      if (plan[r].kind == ROW_REG) begin
        drain();
        reg_write(plan[r].idx, plan[r].data);
      end else begin
        offer_pos(plan[r].x, plan[r].y, '{known: plan[r].known, want: plan[r].want});
      end
    end

    for (p = 0; p < NumPhases; p++) begin
      drain();
      load_random_patch();
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PhaseItems; k++) begin
          offer_pos(rand_pos(), rand_pos(), '{known: 1'b0, want: '0});
          sent++;
          // long output stall with the input still streaming
          if (p == HoldPhase && sent == 20) hold_req = 1'b1;
          if (p == PausePhase && sent == PhaseItems / 2) drain();
        end
        gap = (p == 0 || p == HoldPhase) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
